>>> rtl/dpld_pkg.sv
package dpld_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 22;
    localparam int SERIAL_W = 22;
    localparam int QUOT_W   = 8;
    localparam int MD_W     = 9;

    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

    // floor(x / 100) is (x * RECIP_100) >> RECIP_SHIFT, off by at most one
    // below the true quotient for 14-bit x; a compare-and-subtract fixes it.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam int MAX_COUNT = 3652059;

    // Per-stage load enables of one date datapath.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } dpld_adv_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [MD_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [MD_W-1:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/dpld_date_serial.sv
module dpld_date_serial (
    input  logic                                clk,
    input  dpld_pkg::dpld_adv_t                 adv,
    input  logic [dpld_pkg::YEAR_W-1:0]         year,
    input  logic [dpld_pkg::MONTH_W-1:0]        month,
    input  logic [dpld_pkg::DAY_W-1:0]          day,
    output logic [dpld_pkg::SERIAL_W-1:0]       serial,
    output logic                                ok
);

    // Stage 1: years before this one, and a first estimate of their hundreds.
    logic [dpld_pkg::YEAR_W-1:0]  py_s1;
    logic [26:0]                  prod_s1;
    logic                         ym_ok_s1;

    logic [dpld_pkg::YEAR_W-1:0]  s1_py_reg;
    logic [dpld_pkg::QUOT_W-1:0]  s1_q_reg;
    logic [dpld_pkg::MONTH_W-1:0] s1_m_reg;
    logic [dpld_pkg::DAY_W-1:0]   s1_d_reg;
    logic                         s1_ok_reg;

    assign py_s1    = year - 14'd1;
    assign prod_s1  = 27'(py_s1) * 27'(dpld_pkg::RECIP_100);
    assign ym_ok_s1 = (year != '0) && (year <= dpld_pkg::YEAR_MAX) &&
                      (month != '0) && (month <= dpld_pkg::MONTH_MAX);

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            s1_py_reg <= py_s1;
            s1_q_reg  <= prod_s1[dpld_pkg::RECIP_SHIFT +: dpld_pkg::QUOT_W];
            s1_m_reg  <= month;
            s1_d_reg  <= day;
            s1_ok_reg <= ym_ok_s1;
        end
    end

    // Stage 2: exact quotient and remainder by 100, leap year, day check.
    logic [14:0]                  hund_s2;
    logic [14:0]                  rem_raw_s2;
    logic [6:0]                   rem_s2;
    logic [dpld_pkg::QUOT_W-1:0]  q_s2;
    logic                         leap_s2;
    logic [dpld_pkg::DAY_W-1:0]   len_s2;
    logic                         day_ok_s2;

    logic [dpld_pkg::YEAR_W-1:0]  s2_py_reg;
    logic [dpld_pkg::QUOT_W-1:0]  s2_q_reg;
    logic [dpld_pkg::MONTH_W-1:0] s2_m_reg;
    logic [dpld_pkg::DAY_W-1:0]   s2_d_reg;
    logic                         s2_leap_reg;
    logic                         s2_ok_reg;

    assign hund_s2    = 15'(s1_q_reg) * 15'd100;
    assign rem_raw_s2 = {1'b0, s1_py_reg} - hund_s2;

    always_comb
    begin
        if (rem_raw_s2 >= 15'd100)
        begin
            q_s2   = s1_q_reg + 8'd1;
            rem_s2 = 7'(rem_raw_s2 - 15'd100);
        end
        else
        begin
            q_s2   = s1_q_reg;
            rem_s2 = 7'(rem_raw_s2);
        end
    end

    // The year is py + 1: divisible by 4 when py mod 4 is 3, by 100 when the
    // remainder is 99, and by 400 when in addition the quotient mod 4 is 3.
    assign leap_s2 = ((s1_py_reg[1:0] == 2'b11) && (rem_s2 != 7'd99)) ||
                     ((rem_s2 == 7'd99) && (q_s2[1:0] == 2'b11));

    assign len_s2    = (s1_m_reg == dpld_pkg::MONTH_FEB) ? (leap_s2 ? 5'd29 : 5'd28)
                                                         : dpld_pkg::month_len(s1_m_reg);
    assign day_ok_s2 = (s1_d_reg != '0) && (s1_d_reg <= len_s2);

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            s2_py_reg   <= s1_py_reg;
            s2_q_reg    <= q_s2;
            s2_m_reg    <= s1_m_reg;
            s2_d_reg    <= s1_d_reg;
            s2_leap_reg <= leap_s2;
            s2_ok_reg   <= s1_ok_reg && day_ok_s2;
        end
    end

    // Stage 3: days in whole years, and days within the year.
    logic [dpld_pkg::SERIAL_W-1:0] yd_s3;
    logic [dpld_pkg::MD_W-1:0]     md_s3;

    logic [dpld_pkg::SERIAL_W-1:0] s3_yd_reg;
    logic [dpld_pkg::MD_W-1:0]     s3_md_reg;
    logic                          s3_ok_reg;

    assign yd_s3 = 22'(s2_py_reg) * 22'd365 + 22'(s2_py_reg >> 2)
                 - 22'(s2_q_reg) + 22'(s2_q_reg >> 2);
    assign md_s3 = dpld_pkg::days_before(s2_m_reg)
                 + 9'((s2_m_reg > dpld_pkg::MONTH_FEB) && s2_leap_reg)
                 + 9'(s2_d_reg);

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            s3_yd_reg <= yd_s3;
            s3_md_reg <= md_s3;
            s3_ok_reg <= s2_ok_reg;
        end
    end

    // Stage 4: serial day number.
    logic [dpld_pkg::SERIAL_W-1:0] s4_serial_reg;
    logic                          s4_ok_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            s4_serial_reg <= s3_yd_reg + 22'(s3_md_reg);
            s4_ok_reg     <= s3_ok_reg;
        end
    end

    assign serial = s4_serial_reg;
    assign ok     = s4_ok_reg;

endmodule

>>> rtl/date_period_length_days.sv
// Gregorian date difference in days.
// An item on the input channel carries a start date, an end date and the
// include_end flag; the block returns one result item per input item with
// day_count and date_error. Both channels use valid/ready and an item moves
// at a clock edge where valid and ready are both high.
// Each date is turned into a serial day number (0001-01-01 is day 1) by a
// four-stage datapath: a reciprocal multiply for the division by 100, its
// correction with the leap-year and day checks, the year and in-year day
// sums, and the final add. A fifth stage forms the difference and holds the
// result on the output. A new item can be accepted every cycle unless the
// receiver stalls with every stage full.
// Every stage has its own valid bit; a stage loads when it is empty or when
// the stage after it moves on, so bubbles close up while the receiver stalls
// and in_ready drops only when all five stages hold items.
// An invalid date (year outside 1..9999, month outside 1..12, or day outside
// the month) gives date_error set and day_count zero.
// Reset clears all valid bits, so the block comes up empty and ready.
module date_period_length_days (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dpld_pkg::YEAR_W-1:0]         start_year,
    input  logic [dpld_pkg::MONTH_W-1:0]        start_month,
    input  logic [dpld_pkg::DAY_W-1:0]          start_day,
    input  logic [dpld_pkg::YEAR_W-1:0]         end_year,
    input  logic [dpld_pkg::MONTH_W-1:0]        end_month,
    input  logic [dpld_pkg::DAY_W-1:0]          end_day,
    input  logic                                include_end,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dpld_pkg::COUNT_W-1:0]        day_count,
    output logic                                date_error
);

    // Valid bits of the five stages; the last one is the output register.
    logic [4:0] v_reg;
    logic [4:0] v_next;
    logic [4:0] en;

    // A stage loads when it is empty or when the next stage takes its item.
    assign en[4] = !v_reg[4] || out_ready;
    assign en[3] = !v_reg[3] || en[4];
    assign en[2] = !v_reg[2] || en[3];
    assign en[1] = !v_reg[1] || en[2];
    assign en[0] = !v_reg[0] || en[1];

    assign in_ready = en[0];

    always_comb
    begin
        v_next = v_reg;
        if (en[0]) v_next[0] = in_valid;
        if (en[1]) v_next[1] = v_reg[0];
        if (en[2]) v_next[2] = v_reg[1];
        if (en[3]) v_next[3] = v_reg[2];
        if (en[4]) v_next[4] = v_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    dpld_pkg::dpld_adv_t adv;

    assign adv.s1 = en[0];
    assign adv.s2 = en[1];
    assign adv.s3 = en[2];
    assign adv.s4 = en[3];

    logic [dpld_pkg::SERIAL_W-1:0] start_serial;
    logic [dpld_pkg::SERIAL_W-1:0] end_serial;
    logic                          start_ok;
    logic                          end_ok;

    dpld_date_serial u_start (
        .clk    (clk),
        .adv    (adv),
        .year   (start_year),
        .month  (start_month),
        .day    (start_day),
        .serial (start_serial),
        .ok     (start_ok)
    );

    dpld_date_serial u_end (
        .clk    (clk),
        .adv    (adv),
        .year   (end_year),
        .month  (end_month),
        .day    (end_day),
        .serial (end_serial),
        .ok     (end_ok)
    );

    // The include_end flag rides along with the date datapaths.
    logic [3:0] inc_reg;

    always_ff @(posedge clk)
    begin
        if (en[0]) inc_reg[0] <= include_end;
        if (en[1]) inc_reg[1] <= inc_reg[0];
        if (en[2]) inc_reg[2] <= inc_reg[1];
        if (en[3]) inc_reg[3] <= inc_reg[2];
    end

    // Output stage: serial difference clamped at zero, plus include_end; zero on a date error.
    logic [dpld_pkg::COUNT_W-1:0] count_next;
    logic                         err_next;
    logic [dpld_pkg::COUNT_W-1:0] count_reg;
    logic                         err_reg;

    always_comb
    begin
        err_next = !(start_ok && end_ok);
        if (err_next)
        begin
            count_next = '0;
        end
        else if (start_serial < end_serial)
        begin
            count_next = (end_serial - start_serial) + 22'(inc_reg[3]);
        end
        else
        begin
            count_next = 22'(inc_reg[3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    assign out_valid  = v_reg[4];
    assign day_count  = count_reg;
    assign date_error = err_reg;

`ifndef SYNTHESIS
    // A rejected date never carries a count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && date_error |-> day_count == '0)
        else $error("date error with nonzero day count");

    // The count stays within the span of the calendar.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> day_count <= 22'(dpld_pkg::MAX_COUNT))
        else $error("day count out of range");

    // The input side backs up only when the pipeline is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v_reg == 5'b11111) && !out_ready)
        else $error("input stalled with room in the pipeline");

    // An item accepted into an empty pipeline with the output ready reaches the valid bit of the fourth stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (v_reg == 5'b00000) && out_ready |=>
        ##3 v_reg[3])
        else $error("item lost in the pipeline");
`endif

endmodule
